// File: rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int REQ_W         = 12;
    localparam int OFFSET_W      = 12;
    localparam int FREE_W        = 12;
    localparam int GRANULE_SHIFT = 4;
    // rounded request in granules: up to 2**(REQ_W - GRANULE_SHIFT)
    localparam int AMOUNT_W      = REQ_W - GRANULE_SHIFT + 1;

    localparam logic ACT_ALLOC      = 1'b0;
    localparam logic ACT_FREE       = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOSPACE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  request_bytes;
        logic [REQ_W-1:0]  release_offset;
    } req_t;

    typedef struct packed {
        logic                status;
        logic [OFFSET_W-1:0] data_offset;
        logic [FREE_W-1:0]   free_bytes;
    } rsp_t;

endpackage

// File: rtl/first_fit_heap_allocator_unit.sv
// Channel  | Handshake            | Payload (ffha_pkg) | Direction
// ---------+----------------------+--------------------+----------
// request  | req_valid/req_stall  | req_t  req_data    | in
// response | rsp_valid/rsp_stall  | rsp_t  rsp_data    | out
//
// One request at a time; req_stall is high except in idle. A header read has a read state
// and an evaluate state. Search and free walks read and evaluate each chunk; a merge pass
// does so per chunk visited and absorbed, plus a follower read, evaluate and write per free
// chunk. Worst allocate: search, merge, search. After reset ST_INIT writes the first header.
// A finished response waits in its output register while rsp_stall is high; the next
// request is accepted meanwhile and its result holds in ST_DONE until the register frees.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int POOL_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    // pool geometry in granules; sizes and free count are kept in granules
    localparam int GRANULES     = POOL_BYTES >> GRANULE_SHIFT;
    localparam int GW           = $clog2(GRANULES);
    localparam int PW           = $clog2(GRANULES + 1);
    localparam int CW           = ((GW > AMOUNT_W) ? GW : AMOUNT_W) + 1;
    localparam int OW           = ((PW + GRANULE_SHIFT > REQ_W) ? PW + GRANULE_SHIFT : REQ_W);
    localparam int GRANULE_MASK = (1 << GRANULE_SHIFT) - 1;

    typedef struct packed {
        logic          used;
        logic [GW-1:0] size;   // data granules, header excluded
    } hdr_t;

    typedef enum logic [13:0] {
        ST_INIT  = 14'h0001,
        ST_IDLE  = 14'h0002,
        ST_MA_RD = 14'h0004,   // merge pass: read chunk head
        ST_MA_EV = 14'h0008,
        ST_MF_RD = 14'h0010,   // merge forward: read follower
        ST_MF_EV = 14'h0020,
        ST_MF_WR = 14'h0040,   // write back merged head
        ST_FF_RD = 14'h0080,   // first-fit search
        ST_FF_EV = 14'h0100,
        ST_SPLIT = 14'h0200,   // write remainder header
        ST_TAKE  = 14'h0400,   // mark chunk in use
        ST_FR_RD = 14'h0800,   // free: walk to the named chunk
        ST_FR_EV = 14'h1000,
        ST_DONE  = 14'h2000
    } state_t;

    state_t                state_reg, state_next;
    logic [PW-1:0]         g_reg, g_next;          // current chunk
    logic [PW-1:0]         n_reg, n_next;          // follower during merge
    logic [GW-1:0]         head_reg, head_next;    // size of current chunk
    logic [GW-1:0]         avail_reg, avail_next;
    logic [AMOUNT_W-1:0]   amount_reg, amount_next;
    logic [REQ_W-1:0]      rel_reg, rel_next;
    logic                  action_reg, action_next;
    logic                  merged_reg, merged_next;
    logic                  res_status_reg, res_status_next;
    logic [OFFSET_W-1:0]   res_offset_reg, res_offset_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg;

    logic                  rd_en, wr_en;
    logic [GW-1:0]         rd_addr, wr_addr;
    hdr_t                  rd_hdr, wr_hdr;

    // shared follow adder: base + size + 1 gives the next header position
    logic [PW-1:0]         fol_base;
    logic [GW-1:0]         fol_size;
    logic [PW-1:0]         follow_sum;

    logic [REQ_W:0]        req_round;
    logic [AMOUNT_W-1:0]   req_amount;
    logic [CW-1:0]         amount_cw, avail_cw, size_cw;
    logic [GW-1:0]         amount_gw;
    logic [PW+GRANULE_SHIFT-1:0] off_bytes;
    logic [OW-1:0]         off_ow, rel_ow;
    logic                  g_end, n_end, rsp_load;

    ffha_ram #(
        .WIDTH ($bits(hdr_t)),
        .DEPTH (GRANULES)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_hdr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_hdr)
    );

    assign req_round  = {1'b0, req_data.request_bytes} + (REQ_W+1)'(GRANULE_MASK);
    assign req_amount = req_round[REQ_W:GRANULE_SHIFT];
    assign amount_cw  = CW'(amount_reg);
    assign avail_cw   = CW'(avail_reg);
    assign size_cw    = CW'(rd_hdr.size);
    assign amount_gw  = GW'(amount_reg);
    assign off_bytes  = {g_reg + PW'(1), {GRANULE_SHIFT{1'b0}}};
    assign off_ow     = OW'(off_bytes);
    assign rel_ow     = OW'(rel_reg);
    assign g_end      = (g_reg >= PW'(GRANULES));
    assign n_end      = (n_reg >= PW'(GRANULES));
    assign rsp_load   = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        fol_base = g_reg;
        fol_size = rd_hdr.size;
        unique case (state_reg)
            ST_MF_EV: fol_base = n_reg;
            ST_MF_WR: fol_size = head_reg;
            ST_SPLIT: fol_size = amount_gw;
            default:  ;
        endcase
    end

    assign follow_sum = fol_base + PW'(fol_size) + PW'(1);

    always_comb
    begin
        state_next      = state_reg;
        g_next          = g_reg;
        n_next          = n_reg;
        head_next       = head_reg;
        avail_next      = avail_reg;
        amount_next     = amount_reg;
        rel_next        = rel_reg;
        action_next     = action_reg;
        merged_next     = merged_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        rd_en           = 1'b0;
        rd_addr         = g_reg[GW-1:0];
        wr_en           = 1'b0;
        wr_addr         = g_reg[GW-1:0];
        wr_hdr          = '{used: 1'b0, size: head_reg};

        unique case (state_reg)
            ST_INIT:
            begin
                // whole pool is one free chunk
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_hdr     = '{used: 1'b0, size: GW'(GRANULES - 1)};
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    action_next     = req_data.action;
                    rel_next        = req_data.release_offset;
                    amount_next     = req_amount;
                    g_next          = '0;
                    merged_next     = 1'b0;
                    res_status_next = STATUS_OK;
                    res_offset_next = '0;
                    if (req_data.action == ACT_FREE)
                    begin
                        state_next = ST_FR_RD;
                    end
                    else if (CW'(req_amount) > avail_cw)
                    begin
                        merged_next = 1'b1;
                        state_next  = ST_MA_RD;
                    end
                    else
                    begin
                        state_next = ST_FF_RD;
                    end
                end
            end
            ST_MA_RD:
            begin
                if (g_end)
                begin
                    if (amount_cw > avail_cw)
                    begin
                        res_status_next = STATUS_NOSPACE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        g_next     = '0;
                        state_next = ST_FF_RD;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_MA_EV;
                end
            end
            ST_MA_EV:
            begin
                if (rd_hdr.used)
                begin
                    g_next     = follow_sum;
                    state_next = ST_MA_RD;
                end
                else
                begin
                    head_next  = rd_hdr.size;
                    n_next     = follow_sum;
                    state_next = ST_MF_RD;
                end
            end
            ST_MF_RD:
            begin
                if (n_end)
                begin
                    state_next = ST_MF_WR;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = n_reg[GW-1:0];
                    state_next = ST_MF_EV;
                end
            end
            ST_MF_EV:
            begin
                if (rd_hdr.used)
                begin
                    state_next = ST_MF_WR;
                end
                else
                begin
                    // absorb follower, its header turns into free space
                    head_next  = GW'(head_reg + rd_hdr.size + GW'(1));
                    avail_next = avail_reg + GW'(1);
                    n_next     = follow_sum;
                    state_next = ST_MF_RD;
                end
            end
            ST_MF_WR:
            begin
                wr_en  = 1'b1;
                wr_hdr = '{used: 1'b0, size: head_reg};
                if (action_reg == ACT_FREE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    g_next     = follow_sum;
                    state_next = ST_MA_RD;
                end
            end
            ST_FF_RD:
            begin
                if (g_end)
                begin
                    // a second merge pass would find nothing new
                    if (merged_reg)
                    begin
                        res_status_next = STATUS_NOSPACE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        merged_next = 1'b1;
                        g_next      = '0;
                        state_next  = ST_MA_RD;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_FF_EV;
                end
            end
            ST_FF_EV:
            begin
                if (!rd_hdr.used && (size_cw >= amount_cw))
                begin
                    head_next = rd_hdr.size;
                    if ((size_cw - amount_cw) >= CW'(2))
                    begin
                        state_next = ST_SPLIT;
                    end
                    else
                    begin
                        state_next = ST_TAKE;
                    end
                end
                else
                begin
                    g_next     = follow_sum;
                    state_next = ST_FF_RD;
                end
            end
            ST_SPLIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = follow_sum[GW-1:0];
                wr_hdr     = '{used: 1'b0, size: GW'(head_reg - amount_gw - GW'(1))};
                head_next  = amount_gw;
                avail_next = avail_reg - GW'(1);
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                wr_en           = 1'b1;
                wr_hdr          = '{used: 1'b1, size: head_reg};
                avail_next      = avail_reg - head_reg;
                res_offset_next = OFFSET_W'(off_bytes);
                state_next      = ST_DONE;
            end
            ST_FR_RD:
            begin
                if (g_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_FR_EV;
                end
            end
            ST_FR_EV:
            begin
                if (off_ow == rel_ow)
                begin
                    if (rd_hdr.used)
                    begin
                        avail_next = avail_reg + rd_hdr.size;
                        head_next  = rd_hdr.size;
                        n_next     = follow_sum;
                        state_next = ST_MF_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (off_ow > rel_ow)
                begin
                    // walked past it: not a chunk start, ignore
                    state_next = ST_DONE;
                end
                else
                begin
                    g_next     = follow_sum;
                    state_next = ST_FR_RD;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            avail_reg     <= GW'(GRANULES - 1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            avail_reg     <= avail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg          <= g_next;
        n_reg          <= n_next;
        head_reg       <= head_next;
        amount_reg     <= amount_next;
        rel_reg        <= rel_next;
        action_reg     <= action_next;
        merged_reg     <= merged_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        if (rsp_load)
        begin
            rsp_data_reg.status      <= res_status_reg;
            rsp_data_reg.data_offset <= res_offset_reg;
            rsp_data_reg.free_bytes  <= FREE_W'({avail_reg, {GRANULE_SHIFT{1'b0}}});
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// File: rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
